// ===== hw/rtl/tbt_pkg.sv =====
// Shared types, widths and state encoding for the triangle tangent basis block.
`timescale 1ns / 1ps
package tbt_pkg;

   localparam int FIELD_W = 24;
   localparam int NFIELD  = 5;
   localparam int DIFF_W  = 25;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 64;
   localparam int RES_W   = 51;
   localparam int NORM_W  = 30;
   localparam int SQ_W    = 63;
   localparam int ROOT_W  = 31;
   localparam int REM_W   = 46;
   localparam int Q_W     = 15;
   localparam int OUT_W   = 16;
   localparam int NPROD   = 14;
   localparam int QBITS   = 14;

   typedef logic [NFIELD-1:0][FIELD_W-1:0] vertex_type;
   typedef logic [DIFF_W-1:0] diff_type;

   typedef struct packed {
      diff_type [2:0] e1;
      diff_type [2:0] e2;
      diff_type       d1u;
      diff_type       d1v;
      diff_type       d2u;
      diff_type       d2v;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_SHIFT,
      ST_SQR,
      ST_SQRT,
      ST_DSET,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ===== hw/rtl/tbt_front.sv =====
// Vertex intake: holds two vertices and forms edge and UV deltas on the third.
`timescale 1ns / 1ps
module tbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tbt_pkg::vertex_type vert,
   output logic                job_valid,
   input  logic                job_ready,
   output tbt_pkg::job_type    job
);

   logic [1:0]         phase_ff, phase_in;
   tbt_pkg::vertex_type va_ff, vb_ff;
   logic               take;
   logic               third;

   assign third      = (phase_ff == 2'd2);
   assign req_tready = !third || job_ready;
   assign take       = req_tvalid && req_tready;
   assign job_valid  = req_tvalid && third;

   function automatic tbt_pkg::diff_type sub24(input logic [tbt_pkg::FIELD_W-1:0] x,
                                               input logic [tbt_pkg::FIELD_W-1:0] y);
      sub24 = {x[tbt_pkg::FIELD_W-1], x} - {y[tbt_pkg::FIELD_W-1], y};
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         job.e1[i] = sub24(vb_ff[i], va_ff[i]);
         job.e2[i] = sub24(vert[i], va_ff[i]);
      end
      job.d1u = sub24(vb_ff[3], va_ff[3]);
      job.d1v = sub24(vb_ff[4], va_ff[4]);
      job.d2u = sub24(vert[3], va_ff[3]);
      job.d2v = sub24(vert[4], va_ff[4]);
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            2'd1:    phase_in = 2'd2;
            2'd2:    phase_in = 2'd0;
            default: phase_in = 2'd1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && phase_ff == 2'd1) begin
         vb_ff <= vert;
      end else if (take && !third) begin
         va_ff <= vert;
      end
   end

endmodule

// ===== hw/rtl/tbt_fifo.sv =====
// Two-entry queue of triangle jobs between intake and compute.
`timescale 1ns / 1ps
module tbt_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tbt_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tbt_pkg::job_type pop_data
);

   tbt_pkg::job_type mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/tbt_back.sv =====
// Compute sequencer: shared multiplier, square root and divider, output register.
`timescale 1ns / 1ps
module tbt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  tbt_pkg::job_type job_in,
   output logic             job_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [95:0]      rsp_tdata,
   output logic             rsp_tuser
);

   tbt_pkg::state_type state_ff, state_in;

   tbt_pkg::job_type                 job_ff;
   logic [3:0]                       step_ff;
   logic signed [tbt_pkg::PROD_W-1:0] prod_ff;
   logic signed [tbt_pkg::RES_W-1:0]  acc_ff;
   logic signed [tbt_pkg::RES_W-1:0]  res_ff [7];
   logic                             vec_ff;
   logic [tbt_pkg::RES_W-1:0]        mag_ff [3];
   logic [tbt_pkg::RES_W-1:0]        m_ff;
   logic [2:0]                       neg_ff;
   logic [1:0]                       sq_ff;
   logic [tbt_pkg::SQ_W-1:0]         n_ff, root_ff, bit_ff;
   logic [1:0]                       comp_ff;
   logic [3:0]                       k_ff;
   logic [tbt_pkg::REM_W-1:0]        rem_ff, dsr_ff;
   logic [tbt_pkg::Q_W-1:0]          q_ff;
   logic [tbt_pkg::OUT_W-1:0]        vout_ff [6];
   logic                             degen_ff;
   logic                             out_valid_ff;
   logic [95:0]                      out_data_ff;
   logic                             out_user_ff;

   logic                             out_load;
   logic signed [tbt_pkg::MUL_W-1:0] mul_a, mul_b;
   logic [2:0]                       pj;
   logic [1:0]                       pi;
   logic [3:0]                       pstep;
   logic [tbt_pkg::RES_W-1:0]        ld_mag [3];
   logic [2:0]                       ld_neg;
   logic [tbt_pkg::RES_W-1:0]        ld_max;
   logic [tbt_pkg::SQ_W-1:0]         trial;
   logic                             det_zero;
   logic [tbt_pkg::Q_W-1:0]          q_next;
   logic [tbt_pkg::OUT_W-1:0]        q_ext, q_signed;

   function automatic logic signed [tbt_pkg::MUL_W-1:0] sx(input tbt_pkg::diff_type d);
      sx = $signed({{(tbt_pkg::MUL_W-tbt_pkg::DIFF_W){d[tbt_pkg::DIFF_W-1]}}, d});
   endfunction

   assign det_zero = (res_ff[0] == '0);
   assign pstep    = step_ff - 4'd1;
   assign trial    = root_ff + bit_ff;
   assign q_next   = {q_ff[tbt_pkg::Q_W-2:0], (rem_ff >= dsr_ff)};
   assign q_ext    = {1'b0, q_next};
   assign q_signed = neg_ff[comp_ff] ? (~q_ext + 16'd1) : q_ext;

   // multiplier operand select
   always_comb begin
      pj    = step_ff[3:1];
      pi    = 2'd0;
      mul_a = '0;
      mul_b = '0;
      if (state_ff == tbt_pkg::ST_SQR) begin
         if (sq_ff != 2'd3) begin
            mul_a = $signed({2'b00, mag_ff[sq_ff][tbt_pkg::NORM_W-1:0]});
            mul_b = mul_a;
         end
      end else begin
         unique case (pj)
            3'd0: begin
               mul_a = step_ff[0] ? sx(job_ff.d2u) : sx(job_ff.d1u);
               mul_b = step_ff[0] ? sx(job_ff.d1v) : sx(job_ff.d2v);
            end
            3'd1, 3'd2, 3'd3: begin
               pi    = pj[1:0] - 2'd1;
               mul_a = step_ff[0] ? sx(job_ff.d1v) : sx(job_ff.d2v);
               mul_b = step_ff[0] ? sx(job_ff.e2[pi]) : sx(job_ff.e1[pi]);
            end
            3'd4, 3'd5, 3'd6: begin
               pi    = pj[1:0];
               mul_a = step_ff[0] ? sx(job_ff.d2u) : sx(job_ff.d1u);
               mul_b = step_ff[0] ? sx(job_ff.e1[pi]) : sx(job_ff.e2[pi]);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   // magnitudes and signs of the selected vector
   always_comb begin
      logic signed [tbt_pkg::RES_W-1:0] c;
      ld_max = '0;
      for (int i = 0; i < 3; i++) begin
         c         = vec_ff ? res_ff[4+i] : res_ff[1+i];
         ld_neg[i] = c[tbt_pkg::RES_W-1] ^ res_ff[0][tbt_pkg::RES_W-1];
         ld_mag[i] = c[tbt_pkg::RES_W-1] ? (~c + 1'b1) : c;
         if (ld_mag[i] > ld_max) begin
            ld_max = ld_mag[i];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbt_pkg::ST_IDLE: begin
            if (job_valid) state_in = tbt_pkg::ST_MUL;
         end
         tbt_pkg::ST_MUL: begin
            if (step_ff == 4'(tbt_pkg::NPROD)) state_in = tbt_pkg::ST_LOAD;
         end
         tbt_pkg::ST_LOAD: begin
            state_in = det_zero ? tbt_pkg::ST_FIN : tbt_pkg::ST_SHIFT;
         end
         tbt_pkg::ST_SHIFT: begin
            if (m_ff == '0) begin
               state_in = tbt_pkg::ST_FIN;
            end else if (!(|m_ff[tbt_pkg::RES_W-1:30]) && m_ff[29]) begin
               state_in = tbt_pkg::ST_SQR;
            end
         end
         tbt_pkg::ST_SQR: begin
            if (sq_ff == 2'd3) state_in = tbt_pkg::ST_SQRT;
         end
         tbt_pkg::ST_SQRT: begin
            if (bit_ff[0]) state_in = tbt_pkg::ST_DSET;
         end
         tbt_pkg::ST_DSET: begin
            state_in = tbt_pkg::ST_DIV;
         end
         tbt_pkg::ST_DIV: begin
            if (k_ff == 4'd0) begin
               if (comp_ff != 2'd2) begin
                  state_in = tbt_pkg::ST_DSET;
               end else begin
                  state_in = vec_ff ? tbt_pkg::ST_FIN : tbt_pkg::ST_LOAD;
               end
            end
         end
         tbt_pkg::ST_FIN: begin
            if (out_load) state_in = tbt_pkg::ST_IDLE;
         end
         default: state_in = tbt_pkg::ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      job_pop  = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         tbt_pkg::ST_IDLE: job_pop  = job_valid;
         tbt_pkg::ST_FIN:  out_load = !out_valid_ff || rsp_tready;
         default: begin
            job_pop  = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbt_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         tbt_pkg::ST_IDLE: begin
            job_ff   <= job_in;
            step_ff  <= '0;
            vec_ff   <= 1'b0;
            degen_ff <= 1'b0;
         end
         tbt_pkg::ST_MUL: begin
            step_ff <= step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               if (!pstep[0]) begin
                  acc_ff <= prod_ff[tbt_pkg::RES_W-1:0];
               end else begin
                  res_ff[pstep[3:1]] <= acc_ff - prod_ff[tbt_pkg::RES_W-1:0];
               end
            end
         end
         tbt_pkg::ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= ld_mag[i];
            end
            neg_ff   <= ld_neg;
            m_ff     <= ld_max;
            sq_ff    <= '0;
            n_ff     <= '0;
            root_ff  <= '0;
            bit_ff   <= {1'b1, {(tbt_pkg::SQ_W-1){1'b0}}};
            comp_ff  <= '0;
            degen_ff <= det_zero;
         end
         tbt_pkg::ST_SHIFT: begin
            if (m_ff == '0) begin
               degen_ff <= 1'b1;
            end else if (|m_ff[tbt_pkg::RES_W-1:30]) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               m_ff <= m_ff >> 1;
            end else if (!m_ff[29]) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               m_ff <= m_ff << 1;
            end
         end
         tbt_pkg::ST_SQR: begin
            sq_ff <= sq_ff + 2'd1;
            if (sq_ff != 2'd0) begin
               n_ff <= n_ff + prod_ff[tbt_pkg::SQ_W-1:0];
            end
         end
         tbt_pkg::ST_SQRT: begin
            if (n_ff >= trial) begin
               n_ff    <= n_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         tbt_pkg::ST_DSET: begin
            rem_ff <= {2'b00, mag_ff[comp_ff][tbt_pkg::NORM_W-1:0], {tbt_pkg::QBITS{1'b0}}}
                      + {16'd0, root_ff[tbt_pkg::ROOT_W-1:1]};
            dsr_ff <= {1'b0, root_ff[tbt_pkg::ROOT_W-1:0], {tbt_pkg::QBITS{1'b0}}};
            q_ff   <= '0;
            k_ff   <= 4'(tbt_pkg::QBITS);
         end
         tbt_pkg::ST_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_ff <= rem_ff - dsr_ff;
               q_ff   <= {q_ff[tbt_pkg::Q_W-2:0], 1'b1};
            end else begin
               q_ff <= {q_ff[tbt_pkg::Q_W-2:0], 1'b0};
            end
            dsr_ff <= dsr_ff >> 1;
            k_ff   <= k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               vout_ff[vec_ff ? 3'(comp_ff) + 3'd3 : 3'(comp_ff)] <= q_signed;
               comp_ff <= comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  vec_ff <= 1'b1;
               end
            end
         end
         tbt_pkg::ST_FIN: begin
            if (out_load) begin
               out_user_ff <= degen_ff;
               out_data_ff <= degen_ff ? '0 :
                  {vout_ff[5], vout_ff[4], vout_ff[3], vout_ff[2], vout_ff[1], vout_ff[0]};
            end
         end
         default: begin
            step_ff <= '0;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== hw/rtl/triangle_tangent_basis_top.sv =====
// Top level of the per-triangle tangent and bitangent unit.
//
//  channel | dir | bits                                  | meaning
//  req     | in  | tdata 120                             | one mesh vertex
//  rsp     | out | tdata 96, tuser 1                     | unit tangent, bitangent, degenerate
//
// Vertices one and two of a triangle are taken one per cycle; the third is taken
// once the two-entry job queue has room. Each triangle then occupies the compute
// sequencer alone (14 products on the one 32x32 multiplier, then per vector a
// one-bit-per-cycle range shift, square root and three divisions); the next
// triangle leaves the queue only once the result is in the output register.
// Synchronous active-high reset clears the vertex phase, queue and sequencer.
// A stalled result holds in the output register while the queue keeps filling.
`timescale 1ns / 1ps
module triangle_tangent_basis_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // tangent_x/y/z, bitangent_x/y/z
   output logic         rsp_tuser   // degenerate
);

   tbt_pkg::job_type job_push, job_pop_data;
   logic             push_valid, q_full, q_not_empty, q_pop;

   tbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .vert       (tbt_pkg::vertex_type'(req_tdata)),
      .job_valid  (push_valid),
      .job_ready  (!q_full),
      .job        (job_push)
   );

   tbt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (job_push),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (job_pop_data)
   );

   tbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job_in     (job_pop_data),
      .job_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hw/rtl/tbt_checker.sv =====
// Port-level checks for the tangent basis top level, bound to it.
`timescale 1ns / 1ps
module tbt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [119:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 96'd0)
      else $error("degenerate item carries nonzero vectors");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:0] != 48'd0 && rsp_tdata[95:48] != 48'd0)
      else $error("normal item carries a zero vector");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind triangle_tangent_basis_top tbt_checker u_tbt_checker (.*);

// ===== sim/triangle_tangent_basis_top_test.sv =====
// Testbench for the triangle tangent basis block: directed and random vertices, scoreboard check.
`timescale 1ns / 1ps
module triangle_tangent_basis_top_test;

   typedef struct packed {
      logic [15:0] bz, by, bx, tz, ty, tx;
      logic        degen;
   } basis_type;

   class basis_scoreboard;
      longint va[5];
      longint vb[5];
      int phase;
      basis_type pending[$];
      int errors;
      int shown;

      function new();
         phase = 0;
         errors = 0;
         shown = 0;
         for (int i = 0; i < 5; i++) begin
            va[i] = 0;
            vb[i] = 0;
         end
      endfunction

      function longint unsigned isqrt(longint unsigned n);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > n) bt >>= 2;
         while (bt != 0) begin
            if (n >= res + bt) begin
               n -= res + bt;
               res = (res >> 1) + bt;
            end else begin
               res >>= 1;
            end
            bt >>= 2;
         end
         return res;
      endfunction

      function bit unit_vec(longint c[3], output logic [15:0] q[3]);
         longint unsigned mg[3];
         longint unsigned m, s, len, r;
         m = 0;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            mg[i] = c[i] < 0 ? -c[i] : c[i];
            if (mg[i] > m) m = mg[i];
         end
         if (m == 0) return 0;
         while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mg[i] >>= 1;
            m >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mg[i] <<= 1;
            m <<= 1;
         end
         for (int i = 0; i < 3; i++) s += mg[i] * mg[i];
         len = isqrt(s);
         for (int i = 0; i < 3; i++) begin
            r = (mg[i] * 16384 + (len >> 1)) / len;
            q[i] = c[i] < 0 ? 16'(-r) : 16'(r);
         end
         return 1;
      endfunction

      function void note_vertex(logic [119:0] d);
         longint v[5];
         longint e1[3], e2[3], t[3], b[3];
         longint d1u, d1v, d2u, d2v, det;
         logic [15:0] tq[3], bq[3];
         bit ok;
         basis_type r;
         for (int i = 0; i < 5; i++) v[i] = longint'(signed'(d[i*24 +: 24]));
         if (phase != 2) begin
            if (phase == 1) begin
               vb = v;
               phase = 2;
            end else begin
               va = v;
               phase = 1;
            end
            return;
         end
         phase = 0;
         for (int i = 0; i < 3; i++) begin
            e1[i] = vb[i] - va[i];
            e2[i] = v[i] - va[i];
         end
         d1u = vb[3] - va[3];
         d1v = vb[4] - va[4];
         d2u = v[3] - va[3];
         d2v = v[4] - va[4];
         det = d1u * d2v - d2u * d1v;
         for (int i = 0; i < 3; i++) begin
            t[i] = d2v * e1[i] - d1v * e2[i];
            b[i] = d1u * e2[i] - d2u * e1[i];
            if (det < 0) begin
               t[i] = -t[i];
               b[i] = -b[i];
            end
         end
         ok = det != 0;
         if (ok) ok = unit_vec(t, tq);
         if (ok) ok = unit_vec(b, bq);
         r = '0;
         if (ok) begin
            r.tx = tq[0]; r.ty = tq[1]; r.tz = tq[2];
            r.bx = bq[0]; r.by = bq[1]; r.bz = bq[2];
         end
         r.degen = !ok;
         pending.insert(pending.size(), r);
      endfunction

      function void check_basis(logic [95:0] d, logic u);
         basis_type got, want;
         got = {d, u};
         if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result %h %b", d, u);
            end
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: expected %h %b, got %h %b",
                  want[96:1], want.degen, d, u);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;

   basis_scoreboard board;
   int idle_cycles;

   triangle_tangent_basis_top i_dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(300, 20);
   endfunction

   task automatic send_vertex(logic [119:0] d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      board.note_vertex(d);
      idle_cycles = 0;
   endtask

   function logic [119:0] make_vertex(logic [23:0] base, int spread);
      logic [119:0] d;
      for (int i = 0; i < 5; i++)
         d[i*24 +: 24] = (spread == 0) ? 24'($urandom) :
            base + 24'($urandom_range(2*spread) - spread);
      return d;
   endfunction

   // consumer side: random stalls
   initial begin
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(99) < 30) rsp_tready <= 0;
         else if ($urandom_range(99) < 3) begin
            rsp_tready <= 0;
            repeat ($urandom_range(200, 20)) @(posedge clock);
         end else rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_basis(rsp_tdata, rsp_tuser);
         idle_cycles = 0;
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [119:0] v0, v1, v2;
      int spread;
      board = new();
      idle_cycles = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes
      send_vertex({5{24'h800000}});
      send_vertex({5{24'h7fffff}});
      send_vertex({24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 24'h000000});
      // all identical: zero determinant
      repeat (3) send_vertex({5{24'h001000}});
      // collinear uv: zero determinant
      send_vertex({24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
      send_vertex({24'd4096, 24'd4096, 24'd0, 24'd0, 24'd4096});
      send_vertex({24'd8192, 24'd8192, 24'd0, 24'd4096, 24'd0});
      // collinear positions: parallel tangent and bitangent
      send_vertex({24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
      send_vertex({24'd0, 24'd4096, 24'd0, 24'd4096, 24'd4096});
      send_vertex({24'd4096, 24'd0, 24'd0, 24'd8192, 24'd8192});
      // third position equal to the first, both uv orientations: zero-length vectors
      send_vertex({24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
      send_vertex({24'd0, 24'd4096, 24'd0, 24'd0, 24'd4096});
      send_vertex({24'd4096, 24'd0, 24'd0, 24'd0, 24'd0});
      send_vertex({24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
      send_vertex({24'd4096, 24'd0, 24'd0, 24'd0, 24'd4096});
      send_vertex({24'd0, 24'd4096, 24'd0, 24'd0, 24'd0});
      for (int n = 0; n < 420; n++) begin
         spread = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(22, 2));
         v0 = make_vertex(24'($urandom), 0);
         if ($urandom_range(19) == 0) begin
            v1 = v0;
            v2 = make_vertex(v0[23:0], spread);
         end else begin
            v1 = make_vertex(24'($urandom), spread);
            v2 = make_vertex(24'($urandom), spread);
            if (spread != 0) begin
               v1 = make_vertex(v0[23:0], spread);
               v2 = make_vertex(v0[23:0], spread);
            end
         end
         send_vertex(v0);
         send_vertex(v1);
         send_vertex(v2);
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/tbt_pkg.sv
hw/rtl/tbt_front.sv
hw/rtl/tbt_fifo.sv
hw/rtl/tbt_back.sv
hw/rtl/triangle_tangent_basis_top.sv
hw/rtl/tbt_checker.sv
sim/triangle_tangent_basis_top_test.sv
